// ===== src/rcp_pkg.sv =====
package rcp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int XW = 32;
	localparam int LW = 31;
	localparam int ROOT_STEPS = 32;

	typedef struct packed {
		logic skip;
		logic move_b;
		logic unsup;
		logic neg_x;
		logic neg_y;
		logic signed [XW-1:0] cx;
		logic signed [XW-1:0] cy;
		logic signed [XW-1:0] vx;
		logic signed [XW-1:0] vy;
		logic [LW-1:0] len;
	} item_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_st_t;

	function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [1:0] pair);
		logic [35:0] cur;
		logic [35:0] trial;
		sqrt_st_t o;
		cur = {st.rem, pair};
		trial = {2'b00, st.root, 2'b01};
		if (cur >= trial) begin
			o.rem = 34'(cur - trial);
			o.root = {st.root[30:0], 1'b1};
		end else begin
			o.rem = cur[33:0];
			o.root = {st.root[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
		input logic [31:0] m);
		logic [32:0] cur;
		logic [32:0] o;
		cur = {rem, nbit};
		if (cur >= {1'b0, m}) begin
			o = {32'(cur - {1'b0, m}), 1'b1};
		end else begin
			o = {cur[31:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ===== src/rope_constraint_projector_2d.sv =====
// Rope constraint projector: accepts one item per clock while the output is not stalled
// and returns one result per item, in order. The pipeline includes the square root,
// which resolves one root bit per stage over 32 stages, and the divider for the unit
// vector, which resolves one quotient bit per stage. All stages advance together and
// hold while a result waits at the output, so throughput is one item per cycle whenever
// the output is taken.
module rope_constraint_projector_2d #(
	parameter int FRAC_BITS = rcp_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] vel_a_x,
	input  logic signed [31:0] vel_a_y,
	input  logic signed [31:0] vel_b_x,
	input  logic signed [31:0] vel_b_y,
	input  logic fixed_a,
	input  logic fixed_b,
	input  logic [30:0] rope_length,
	output logic out_valid,
	input  logic out_ready,
	output logic corrected,
	output logic moved_end,
	output logic unsupported,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y
);
	import rcp_pkg::*;

	logic en;
	logic f_valid, q_valid, d_valid;
	item_t f_item, q_item, d_item;
	logic [31:0] f_ax, f_ay, q_ax, q_ay, q_m;
	logic [63:0] f_s;
	logic d_mzero;
	logic [FRAC_BITS:0] d_qx, d_qy;

	assign en = ~out_valid | out_ready;
	assign in_ready = en;

	rcp_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
		.vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
		.fixed_a(fixed_a), .fixed_b(fixed_b), .rope_length(rope_length),
		.o_valid(f_valid), .o_item(f_item), .o_ax(f_ax), .o_ay(f_ay), .o_s(f_s)
	);

	rcp_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .i_valid(f_valid), .i_item(f_item),
		.i_ax(f_ax), .i_ay(f_ay), .i_s(f_s),
		.o_valid(q_valid), .o_item(q_item), .o_ax(q_ax), .o_ay(q_ay), .o_m(q_m)
	);

	rcp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .i_valid(q_valid), .i_item(q_item),
		.i_ax(q_ax), .i_ay(q_ay), .i_m(q_m),
		.o_valid(d_valid), .o_item(d_item), .o_mzero(d_mzero), .o_qx(d_qx), .o_qy(d_qy)
	);

	rcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .i_valid(d_valid), .i_item(d_item),
		.i_mzero(d_mzero), .i_qx(d_qx), .i_qy(d_qy),
		.o_valid(out_valid), .corrected(corrected), .moved_end(moved_end),
		.unsupported(unsupported), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
		.new_vel_x(new_vel_x), .new_vel_y(new_vel_y)
	);

	a_zero_when_uncorrected: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !corrected) |-> (!moved_end && !unsupported && new_pos_x == 0 &&
		new_pos_y == 0 && new_vel_x == 0 && new_vel_y == 0))
		else $error("uncorrected item carries nonzero fields");

	a_unsup_moves_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unsupported) |-> (corrected && !moved_end))
		else $error("unsupported item must move end A");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(d_valid) && $stable(q_valid)))
		else $error("pipeline advanced during a stall");

endmodule

// ===== src/rcp_front.sv =====
module rcp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] vel_a_x,
	input  logic signed [31:0] vel_a_y,
	input  logic signed [31:0] vel_b_x,
	input  logic signed [31:0] vel_b_y,
	input  logic fixed_a,
	input  logic fixed_b,
	input  logic [30:0] rope_length,
	output logic o_valid,
	output rcp_pkg::item_t o_item,
	output logic [31:0] o_ax,
	output logic [31:0] o_ay,
	output logic [63:0] o_s
);
	import rcp_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5;
	logic signed [31:0] mx_s1, my_s1;
	logic [32:0] ax_s2, ay_s2;
	logic [31:0] ax_s3, ay_s3, ax_s4, ay_s4, ax_s5, ay_s5;
	logic big_s3, big_s4;
	logic [63:0] sqx_s4, sqy_s4, s_s5;
	logic [61:0] l2_s4;
	logic signed [32:0] dx, dy;
	logic big;
	logic [63:0] s_sum;
	item_t it_n2, it_n5;

	always_comb begin
		dx = {mx_s1[31], mx_s1} - {it_s1.cx[31], it_s1.cx};
		dy = {my_s1[31], my_s1} - {it_s1.cy[31], it_s1.cy};
		big = ax_s2[32] | ax_s2[31] | ay_s2[32] | ay_s2[31];
		s_sum = sqx_s4 + sqy_s4;
		it_n2 = it_s1;
		it_n2.neg_x = dx[32];
		it_n2.neg_y = dy[32];
		it_n5 = it_s4;
		it_n5.skip = it_s4.skip | (~big_s4 & (s_sum < {2'b00, l2_s4}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.skip <= fixed_a & fixed_b;
			it_s1.move_b <= fixed_a;
			it_s1.unsup <= ~fixed_a & ~fixed_b;
			it_s1.neg_x <= 1'b0;
			it_s1.neg_y <= 1'b0;
			it_s1.len <= rope_length;
			if (fixed_a) begin
				it_s1.cx <= pos_a_x;
				it_s1.cy <= pos_a_y;
				it_s1.vx <= vel_b_x;
				it_s1.vy <= vel_b_y;
				mx_s1 <= pos_b_x;
				my_s1 <= pos_b_y;
			end else begin
				it_s1.cx <= pos_b_x;
				it_s1.cy <= pos_b_y;
				it_s1.vx <= vel_a_x;
				it_s1.vy <= vel_a_y;
				mx_s1 <= pos_a_x;
				my_s1 <= pos_a_y;
			end

			it_s2 <= it_n2;
			ax_s2 <= dx[32] ? 33'(-dx) : 33'(dx);
			ay_s2 <= dy[32] ? 33'(-dy) : 33'(dy);

			it_s3 <= it_s2;
			big_s3 <= big;
			ax_s3 <= big ? ax_s2[32:1] : ax_s2[31:0];
			ay_s3 <= big ? ay_s2[32:1] : ay_s2[31:0];

			it_s4 <= it_s3;
			big_s4 <= big_s3;
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			sqx_s4 <= 64'(ax_s3) * 64'(ax_s3);
			sqy_s4 <= 64'(ay_s3) * 64'(ay_s3);
			l2_s4 <= 62'(it_s3.len) * 62'(it_s3.len);

			it_s5 <= it_n5;
			ax_s5 <= ax_s4;
			ay_s5 <= ay_s4;
			s_s5 <= s_sum;
		end
	end

	assign o_valid = valid_s5;
	assign o_item = it_s5;
	assign o_ax = ax_s5;
	assign o_ay = ay_s5;
	assign o_s = s_s5;

endmodule

// ===== src/rcp_isqrt.sv =====
module rcp_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic i_valid,
	input  rcp_pkg::item_t i_item,
	input  logic [31:0] i_ax,
	input  logic [31:0] i_ay,
	input  logic [63:0] i_s,
	output logic o_valid,
	output rcp_pkg::item_t o_item,
	output logic [31:0] o_ax,
	output logic [31:0] o_ay,
	output logic [31:0] o_m
);
	import rcp_pkg::*;

	logic valid_s [ROOT_STEPS];
	item_t it_s [ROOT_STEPS];
	logic [31:0] ax_s [ROOT_STEPS];
	logic [31:0] ay_s [ROOT_STEPS];
	logic [63:0] s_s [ROOT_STEPS];
	sqrt_st_t st_s [ROOT_STEPS];
	sqrt_st_t zero_st;

	assign zero_st = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= i_valid;
			for (int k = 1; k < ROOT_STEPS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[0] <= i_item;
			ax_s[0] <= i_ax;
			ay_s[0] <= i_ay;
			s_s[0] <= i_s;
			st_s[0] <= sqrt_step(zero_st, i_s[63:62]);
			for (int k = 1; k < ROOT_STEPS; k++) begin
				it_s[k] <= it_s[k-1];
				ax_s[k] <= ax_s[k-1];
				ay_s[k] <= ay_s[k-1];
				s_s[k] <= s_s[k-1];
				st_s[k] <= sqrt_step(st_s[k-1], s_s[k-1][63-2*k -: 2]);
			end
		end
	end

	assign o_valid = valid_s[ROOT_STEPS-1];
	assign o_item = it_s[ROOT_STEPS-1];
	assign o_ax = ax_s[ROOT_STEPS-1];
	assign o_ay = ay_s[ROOT_STEPS-1];
	assign o_m = st_s[ROOT_STEPS-1].root;

endmodule

// ===== src/rcp_div.sv =====
module rcp_div #(
	parameter int FRAC_BITS = rcp_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic i_valid,
	input  rcp_pkg::item_t i_item,
	input  logic [31:0] i_ax,
	input  logic [31:0] i_ay,
	input  logic [31:0] i_m,
	output logic o_valid,
	output rcp_pkg::item_t o_item,
	output logic o_mzero,
	output logic [FRAC_BITS:0] o_qx,
	output logic [FRAC_BITS:0] o_qy
);
	import rcp_pkg::*;

	localparam int STEPS = FRAC_BITS + 1;

	logic valid_s [STEPS];
	item_t it_s [STEPS];
	logic [31:0] m_s [STEPS];
	logic [31:0] rx_s [STEPS];
	logic [31:0] ry_s [STEPS];
	logic [FRAC_BITS:0] qx_s [STEPS];
	logic [FRAC_BITS:0] qy_s [STEPS];
	logic [32:0] sx0, sy0;

	assign sx0 = div_step({1'b0, i_ax[31:1]}, i_ax[0], i_m);
	assign sy0 = div_step({1'b0, i_ay[31:1]}, i_ay[0], i_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= i_valid;
			for (int k = 1; k < STEPS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0] tx;
		logic [32:0] ty;
		if (en) begin
			it_s[0] <= i_item;
			m_s[0] <= i_m;
			rx_s[0] <= sx0[32:1];
			ry_s[0] <= sy0[32:1];
			qx_s[0] <= {{FRAC_BITS{1'b0}}, sx0[0]};
			qy_s[0] <= {{FRAC_BITS{1'b0}}, sy0[0]};
			for (int k = 1; k < STEPS; k++) begin
				tx = div_step(rx_s[k-1], 1'b0, m_s[k-1]);
				ty = div_step(ry_s[k-1], 1'b0, m_s[k-1]);
				it_s[k] <= it_s[k-1];
				m_s[k] <= m_s[k-1];
				rx_s[k] <= tx[32:1];
				ry_s[k] <= ty[32:1];
				qx_s[k] <= {qx_s[k-1][FRAC_BITS-1:0], tx[0]};
				qy_s[k] <= {qy_s[k-1][FRAC_BITS-1:0], ty[0]};
			end
		end
	end

	assign o_valid = valid_s[STEPS-1];
	assign o_item = it_s[STEPS-1];
	assign o_mzero = (m_s[STEPS-1] == 32'd0);
	assign o_qx = qx_s[STEPS-1];
	assign o_qy = qy_s[STEPS-1];

endmodule

// ===== src/rcp_back.sv =====
module rcp_back #(
	parameter int FRAC_BITS = rcp_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic i_valid,
	input  rcp_pkg::item_t i_item,
	input  logic i_mzero,
	input  logic [FRAC_BITS:0] i_qx,
	input  logic [FRAC_BITS:0] i_qy,
	output logic o_valid,
	output logic corrected,
	output logic moved_end,
	output logic unsupported,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y
);
	import rcp_pkg::*;

	localparam int UW = FRAC_BITS + 2;
	localparam int PW = 32 + UW;
	localparam int SUMW = PW + 1;
	localparam int RW = 34;
	localparam int TW = UW + RW;
	localparam int DW = 36;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic signed [UW-1:0] ux_s1, uy_s1, ux_s2, uy_s2, ux_s3, uy_s3, ux_s4, uy_s4;
	logic signed [PW-1:0] pvx_s2, pvy_s2, plx_s2, ply_s2;
	logic signed [SUMW-1:0] sum_s3;
	logic signed [33:0] ox_s3, oy_s3;
	logic signed [RW-1:0] r_s4;
	logic signed [31:0] npx_s4, npy_s4, npx_s5, npy_s5, npx_s6, npy_s6;
	logic signed [TW-1:0] tx_s5, ty_s5;
	logic rpos_s5, rpos_s6;
	logic signed [DW-1:0] dvx_s6, dvy_s6;

	logic signed [UW-1:0] ux, uy;
	logic signed [PW-1:0] plx_t, ply_t;
	logic signed [SUMW-1:0] sum_t;
	logic signed [TW-1:0] tx_t, ty_t;
	logic signed [33:0] px, py;
	logic signed [36:0] vdx, vdy;
	logic signed [31:0] sat_px, sat_py, sat_vx, sat_vy;

	always_comb begin
		ux = i_item.neg_x ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
		uy = i_item.neg_y ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});
		if (i_mzero) begin
			ux = '0;
			uy = '0;
		end
		plx_t = plx_s2 + (plx_s2[PW-1] ? PW'({FRAC_BITS{1'b1}}) : PW'(0));
		ply_t = ply_s2 + (ply_s2[PW-1] ? PW'({FRAC_BITS{1'b1}}) : PW'(0));
		sum_t = sum_s3 + (sum_s3[SUMW-1] ? SUMW'({FRAC_BITS{1'b1}}) : SUMW'(0));
		tx_t = tx_s5 + (tx_s5[TW-1] ? TW'({FRAC_BITS{1'b1}}) : TW'(0));
		ty_t = ty_s5 + (ty_s5[TW-1] ? TW'({FRAC_BITS{1'b1}}) : TW'(0));
		px = 34'(it_s3.cx) + ox_s3;
		py = 34'(it_s3.cy) + oy_s3;
		sat_px = (px[33:31] == 3'b000 || px[33:31] == 3'b111) ? px[31:0] :
			(px[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
		sat_py = (py[33:31] == 3'b000 || py[33:31] == 3'b111) ? py[31:0] :
			(py[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
		vdx = 37'(it_s6.vx) - 37'(dvx_s6);
		vdy = 37'(it_s6.vy) - 37'(dvy_s6);
		sat_vx = (vdx[36:31] == 6'b000000 || vdx[36:31] == 6'b111111) ? vdx[31:0] :
			(vdx[36] ? 32'sh8000_0000 : 32'sh7fff_ffff);
		sat_vy = (vdy[36:31] == 6'b000000 || vdy[36:31] == 6'b111111) ? vdy[31:0] :
			(vdy[36] ? 32'sh8000_0000 : 32'sh7fff_ffff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= i_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= i_item;
			ux_s1 <= ux;
			uy_s1 <= uy;

			it_s2 <= it_s1;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			pvx_s2 <= PW'(it_s1.vx) * PW'(ux_s1);
			pvy_s2 <= PW'(it_s1.vy) * PW'(uy_s1);
			plx_s2 <= PW'(ux_s1) * $signed(PW'({1'b0, it_s1.len}));
			ply_s2 <= PW'(uy_s1) * $signed(PW'({1'b0, it_s1.len}));

			it_s3 <= it_s2;
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			sum_s3 <= SUMW'(pvx_s2) + SUMW'(pvy_s2);
			ox_s3 <= 34'(plx_t >>> FRAC_BITS);
			oy_s3 <= 34'(ply_t >>> FRAC_BITS);

			it_s4 <= it_s3;
			ux_s4 <= ux_s3;
			uy_s4 <= uy_s3;
			r_s4 <= RW'(sum_t >>> FRAC_BITS);
			npx_s4 <= sat_px;
			npy_s4 <= sat_py;

			it_s5 <= it_s4;
			npx_s5 <= npx_s4;
			npy_s5 <= npy_s4;
			tx_s5 <= TW'(ux_s4) * TW'(r_s4);
			ty_s5 <= TW'(uy_s4) * TW'(r_s4);
			rpos_s5 <= ~r_s4[RW-1] && (r_s4 != '0);

			it_s6 <= it_s5;
			npx_s6 <= npx_s5;
			npy_s6 <= npy_s5;
			rpos_s6 <= rpos_s5;
			dvx_s6 <= DW'(tx_t >>> FRAC_BITS);
			dvy_s6 <= DW'(ty_t >>> FRAC_BITS);

			if (it_s6.skip) begin
				corrected <= 1'b0;
				moved_end <= 1'b0;
				unsupported <= 1'b0;
				new_pos_x <= '0;
				new_pos_y <= '0;
				new_vel_x <= '0;
				new_vel_y <= '0;
			end else begin
				corrected <= 1'b1;
				moved_end <= it_s6.move_b;
				unsupported <= it_s6.unsup;
				new_pos_x <= npx_s6;
				new_pos_y <= npy_s6;
				new_vel_x <= rpos_s6 ? sat_vx : it_s6.vx;
				new_vel_y <= rpos_s6 ? sat_vy : it_s6.vy;
			end
		end
	end

	assign o_valid = valid_s7;

endmodule
